### src/ps2md_pkg.sv
// ps2md_pkg: shared types and constants for the ps/2 mouse packet decoder
// no dependencies; imported by ps2md_decode, ps2_mouse_packet_decoder and ps2md_checker
`default_nettype none

package ps2md_pkg;

    // packet phase: which byte of the three-byte packet is expected next
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X      = 2'd1,
        PH_Y      = 2'd2
    } phase_t;

    // event codes on event_kind
    localparam logic [2:0] KIND_MIDDLE = 3'd0;
    localparam logic [2:0] KIND_RIGHT  = 3'd1;
    localparam logic [2:0] KIND_LEFT   = 3'd2;
    localparam logic [2:0] KIND_X_MOVE = 3'd3;
    localparam logic [2:0] KIND_Y_MOVE = 3'd4;

    // header byte bit positions
    localparam int unsigned HDR_LEFT_BIT   = 0;
    localparam int unsigned HDR_RIGHT_BIT  = 1;
    localparam int unsigned HDR_MIDDLE_BIT = 2;
    localparam int unsigned HDR_SYNC_BIT   = 3;
    localparam int unsigned HDR_XSIGN_BIT  = 4;
    localparam int unsigned HDR_YSIGN_BIT  = 5;
    localparam int unsigned HDR_XOVF_BIT   = 6;
    localparam int unsigned HDR_YOVF_BIT   = 7;

    // magnitude of a negative move is this minus the byte
    localparam logic [8:0] MOVE_WRAP = 9'h100;

    // one decoded event plus the bookkeeping the holding stage needs
    typedef struct packed {
        logic       has_event;   // an event is still due from the held byte
        logic       one_left;    // the due event is the final one for this byte
        logic [2:0] kind;
        logic       released;
        logic       negative;
        logic [8:0] magnitude;
        logic [2:0] toggle_mask; // button bit that flips once the event is sent
    } dec_t;

endpackage

`default_nettype wire

### src/ps2md_decode.sv
// ps2md_decode: picks the next event due from the held byte and the decoder state
// depends on ps2md_pkg
`default_nettype none

module ps2md_decode (
    input  wire logic [7:0]          rx_byte,
    input  wire logic [1:0]          phase,
    input  wire logic [2:0]          buttons,
    input  wire logic [1:0]          signs,
    output ps2md_pkg::dec_t          dec
);
    import ps2md_pkg::*;

    logic       header_ok;
    logic [2:0] pending;
    logic       move_neg;
    logic [8:0] move_mag;

    // header is usable only with the sync bit set and no overflow
    assign header_ok = rx_byte[HDR_SYNC_BIT] & ~rx_byte[HDR_XOVF_BIT]
                     & ~rx_byte[HDR_YOVF_BIT];

    // buttons still differing from the stored state
    assign pending = header_ok ? (rx_byte[2:0] ^ buttons) : 3'b000;

    // movement as sign plus magnitude
    assign move_neg = (phase == PH_X) ? signs[0] : signs[1];
    assign move_mag = move_neg ? (MOVE_WRAP - {1'b0, rx_byte}) : {1'b0, rx_byte};

    // event selection, middle before right before left
    always_comb
    begin
        dec = '0;
        case (phase)
            PH_X, PH_Y:
            begin
                dec.has_event = 1'b1;
                dec.one_left  = 1'b1;
                dec.kind      = (phase == PH_X) ? KIND_X_MOVE : KIND_Y_MOVE;
                dec.negative  = move_neg;
                dec.magnitude = move_mag;
            end
            default:
            begin
                dec.has_event = |pending;
                dec.one_left  = (pending == 3'b001) || (pending == 3'b010)
                             || (pending == 3'b100);
                if (pending[HDR_MIDDLE_BIT])
                begin
                    dec.kind        = KIND_MIDDLE;
                    dec.released    = ~rx_byte[HDR_MIDDLE_BIT];
                    dec.toggle_mask = 3'b100;
                end
                else if (pending[HDR_RIGHT_BIT])
                begin
                    dec.kind        = KIND_RIGHT;
                    dec.released    = ~rx_byte[HDR_RIGHT_BIT];
                    dec.toggle_mask = 3'b010;
                end
                else if (pending[HDR_LEFT_BIT])
                begin
                    dec.kind        = KIND_LEFT;
                    dec.released    = ~rx_byte[HDR_LEFT_BIT];
                    dec.toggle_mask = 3'b001;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### src/ps2_mouse_packet_decoder.sv
// ps2_mouse_packet_decoder: an accepted byte is registered in the holding stage; each event it
// causes is registered in the output stage, one event per cycle while the output is not stalled.
// a header gives 0 to 3 events, a move byte 1; a byte holds the input stage until its last is sent.
// a new byte is taken while an earlier event still waits in the output register.
// reset (rst_n, asynchronous, active low): header phase, all buttons released, signs zero,
// input and output stages empty.
`default_nettype none

module ps2_mouse_packet_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_stall,
    input  wire logic [7:0] rx_byte,
    output logic            ev_valid,
    input  wire logic       ev_stall,
    output logic [2:0]      event_kind,
    output logic            released,
    output logic            negative,
    output logic [8:0]      magnitude,
    output logic            last
);
    import ps2md_pkg::*;

    // holding stage
    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_byte_reg;

    // decoder state
    phase_t     phase_reg, phase_next;
    logic [2:0] buttons_reg, buttons_next;
    logic [1:0] signs_reg, signs_next;

    // output stage
    logic       out_valid_reg, out_valid_next;
    logic [2:0] out_kind_reg;
    logic       out_released_reg;
    logic       out_negative_reg;
    logic [8:0] out_magnitude_reg;
    logic       out_last_reg;

    dec_t       dec;
    logic       can_load;
    logic       emit;
    logic       finish;
    logic       rx_take;
    logic       header_ok;

    ps2md_decode u_decode (
        .rx_byte (hold_byte_reg),
        .phase   (phase_reg),
        .buttons (buttons_reg),
        .signs   (signs_reg),
        .dec     (dec)
    );

    // handshake between holding stage and output register
    assign can_load = ~out_valid_reg | ~ev_stall;
    assign emit     = hold_valid_reg & dec.has_event & can_load;
    assign finish   = hold_valid_reg & (~dec.has_event | (emit & dec.one_left));
    assign rx_stall = hold_valid_reg & ~finish;
    assign rx_take  = rx_valid & ~rx_stall;

    assign header_ok = hold_byte_reg[HDR_SYNC_BIT] & ~hold_byte_reg[HDR_XOVF_BIT]
                     & ~hold_byte_reg[HDR_YOVF_BIT];

    // holding stage occupancy
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (rx_take)
            hold_valid_next = 1'b1;
        else if (finish)
            hold_valid_next = 1'b0;
    end

    // packet phase and header sign capture, once the held byte is done
    always_comb
    begin
        phase_next = phase_reg;
        signs_next = signs_reg;
        if (finish)
        begin
            case (phase_reg)
                PH_X:    phase_next = PH_Y;
                PH_Y:    phase_next = PH_HEADER;
                default:
                begin
                    if (header_ok)
                    begin
                        phase_next = PH_X;
                        signs_next = {hold_byte_reg[HDR_YSIGN_BIT],
                                      hold_byte_reg[HDR_XSIGN_BIT]};
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                    end
                end
            endcase
        end
    end

    // button state follows each button event as it is sent
    always_comb
    begin
        buttons_next = buttons_reg;
        if (emit)
            buttons_next = buttons_reg ^ dec.toggle_mask;
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (~ev_stall)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= PH_HEADER;
            buttons_reg    <= 3'b000;
            signs_reg      <= 2'b00;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            buttons_reg    <= buttons_next;
            signs_reg      <= signs_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rx_take)
            hold_byte_reg <= rx_byte;
        if (emit)
        begin
            out_kind_reg      <= dec.kind;
            out_released_reg  <= dec.released;
            out_negative_reg  <= dec.negative;
            out_magnitude_reg <= dec.magnitude;
            out_last_reg      <= dec.one_left;
        end
    end

    assign ev_valid   = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign released   = out_released_reg;
    assign negative   = out_negative_reg;
    assign magnitude  = out_magnitude_reg;
    assign last       = out_last_reg;

endmodule

`default_nettype wire

### src/ps2md_checker.sv
// ps2md_checker: port-level assertions for ps2_mouse_packet_decoder, bound to the top level
// depends on ps2md_pkg and ps2_mouse_packet_decoder
`default_nettype none

module ps2md_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       ev_valid,
    input  wire logic       ev_stall,
    input  wire logic [2:0] event_kind,
    input  wire logic       released,
    input  wire logic       negative,
    input  wire logic [8:0] magnitude
);
    import ps2md_pkg::*;

    // a stalled beat stays on the output
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_stall |=> ev_valid)
        else $error("output beat dropped while stalled");

    // only the five defined event kinds appear
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> (event_kind <= KIND_Y_MOVE))
        else $error("undefined event kind");

    // button events carry no movement
    a_button_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && (event_kind == KIND_MIDDLE || event_kind == KIND_RIGHT
                     || event_kind == KIND_LEFT)
        |-> !negative && (magnitude == 9'd0))
        else $error("button event with movement fields set");

    // move events never flag a release and stay within 256
    a_move_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && (event_kind == KIND_X_MOVE || event_kind == KIND_Y_MOVE)
        |-> !released && (magnitude <= MOVE_WRAP))
        else $error("move event with bad release flag or magnitude");

    // full 256 magnitude only arises from a negative move
    a_full_is_negative: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && (magnitude == MOVE_WRAP) |-> negative)
        else $error("magnitude 256 on a positive move");

endmodule

bind ps2_mouse_packet_decoder ps2md_checker u_ps2md_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_valid   (ev_valid),
    .ev_stall   (ev_stall),
    .event_kind (event_kind),
    .released   (released),
    .negative   (negative),
    .magnitude  (magnitude)
);

`default_nettype wire
